/* rtl/adm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package adm_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 64;
   localparam int MAX_RESULTS         = 64;
   localparam int CMD_Q_DEPTH         = 2;
   localparam int RSP_Q_DEPTH         = 2;

   localparam int MB_W      = 12;
   localparam int ACTIVE_W  = 16;
   localparam int ID_W      = 16;
   localparam int BYTES_W   = 32;
   localparam int ELAPSED_W = 24;
   localparam int QUOTA_W   = 48;
   localparam int MB_SHIFT  = 20;

   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_BANDWIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ACTIVE = 1'b1;

   localparam logic [MB_W-1:0]     BANDWIDTH_RESET  = 12'd100;
   localparam logic [ACTIVE_W-1:0] MAX_ACTIVE_RESET = 16'd10000;

   // drain = x * 2^20 / 10^6 = x + x * 759 / 15625, where x = elapsed * mb
   localparam int X_W        = ELAPSED_W + MB_W;
   localparam int TAIL_MUL_W = 10;
   localparam logic [TAIL_MUL_W-1:0] DRAIN_TAIL_MUL = 10'd759;
   localparam int DVD_W      = 48;
   // y / 15625 = (y * ceil(2^60 / 15625)) >> 60 for any y below 2^46
   localparam int RECIP_W     = 47;
   localparam logic [RECIP_W-1:0] DRAIN_RECIP = 47'd73786976294839;
   localparam int RECIP_SHIFT = 60;
   localparam int HALF_W      = DVD_W / 2;
   localparam int PART_W      = HALF_W + RECIP_W;
   localparam int PROD_W      = DVD_W + RECIP_W;
   localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
   localparam int DRAIN_W    = X_W + 1;

   typedef enum logic [1:0] {
      KIND_SUBMIT,
      KIND_COMPLETE,
      KIND_TICK,
      KIND_CLEAR
   } kind_type;

   typedef enum logic [1:0] {
      EV_DISPATCH,
      EV_QUEUED,
      EV_DROPPED,
      EV_ACK
   } event_type;

   typedef struct packed {
      kind_type             kind;
      logic [ID_W-1:0]      task_id;
      logic [BYTES_W-1:0]   est;
      logic [BYTES_W-1:0]   used;
      logic [DRAIN_W-1:0]   drain;
   } cmd_type;

   typedef struct packed {
      event_type                  ev;
      logic [ID_W-1:0]            task_id;
      logic [ACTIVE_W-1:0]        active;
      logic signed [QUOTA_W-1:0]  used_quota;
      logic                       last;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/adm_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module adm_fifo #(
   parameter type word_type = logic,
   parameter int  DEPTH     = 2
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   output logic          full,
   input  wire word_type wr_word,
   input  wire logic     pop,
   output logic          empty,
   output word_type      rd_word
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   word_type             slot_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_word = slot_ff[rd_ptr_ff];
   assign do_wr   = push && !full;
   assign do_rd   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_word;
      end
   end

endmodule

`default_nettype wire

/* rtl/adm_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module adm_front
   import adm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   output logic                       full,
   input  wire logic [1:0]            req_kind,
   input  wire logic [ID_W-1:0]       req_task_id,
   input  wire logic [BYTES_W-1:0]    req_estimate_bytes,
   input  wire logic [BYTES_W-1:0]    req_used_bytes,
   input  wire logic [ELAPSED_W-1:0]  req_elapsed_us,
   input  wire logic [MB_W-1:0]       bandwidth_mb,
   output logic                       cmd_push,
   input  wire logic                  cmd_full,
   output cmd_type                    cmd_word
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL_X,
      S_MUL_TAIL,
      S_REC_LO,
      S_REC_HI,
      S_SUM,
      S_PUSH
   } state_type;

   state_type               state_ff;
   cmd_type                 word_ff;
   logic [ELAPSED_W-1:0]    elapsed_ff;
   logic [X_W-1:0]          x_ff;
   logic [DVD_W-1:0]        dvd_ff;
   logic [PART_W-1:0]       prod_lo_ff;
   logic [PART_W-1:0]       prod_hi_ff;
   logic [QUOT_W-1:0]       quot_ff;
   logic [PROD_W-1:0]       prod_sum;

   assign full     = (state_ff != S_IDLE);
   assign cmd_push = (state_ff == S_PUSH);

   // reciprocal multiply by the constant, one half of the dividend per cycle
   assign prod_sum = PROD_W'(prod_lo_ff) + {prod_hi_ff, {HALF_W{1'b0}}};

   always_comb begin
      cmd_word       = word_ff;
      cmd_word.drain = DRAIN_W'(x_ff) + DRAIN_W'(quot_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (push) begin
                  word_ff.kind    <= kind_type'(req_kind);
                  word_ff.task_id <= req_task_id;
                  word_ff.est     <= req_estimate_bytes;
                  word_ff.used    <= req_used_bytes;
                  word_ff.drain   <= '0;
                  elapsed_ff      <= req_elapsed_us;
                  state_ff        <= (kind_type'(req_kind) == KIND_TICK) ? S_MUL_X : S_PUSH;
               end
            end
            S_MUL_X: begin
               x_ff     <= X_W'(elapsed_ff) * X_W'(bandwidth_mb);
               state_ff <= S_MUL_TAIL;
            end
            S_MUL_TAIL: begin
               dvd_ff   <= DVD_W'(x_ff) * DVD_W'(DRAIN_TAIL_MUL);
               state_ff <= S_REC_LO;
            end
            S_REC_LO: begin
               prod_lo_ff <= PART_W'(dvd_ff[HALF_W-1:0]) * PART_W'(DRAIN_RECIP);
               state_ff   <= S_REC_HI;
            end
            S_REC_HI: begin
               prod_hi_ff <= PART_W'(dvd_ff[DVD_W-1:HALF_W]) * PART_W'(DRAIN_RECIP);
               state_ff   <= S_SUM;
            end
            S_SUM: begin
               quot_ff  <= prod_sum[PROD_W-1:RECIP_SHIFT];
               state_ff <= S_PUSH;
            end
            S_PUSH: begin
               if (!cmd_full) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

/* rtl/adm_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

module adm_engine
   import adm_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [MB_W-1:0]      bandwidth_mb,
   input  wire logic [ACTIVE_W-1:0]  max_active,
   input  wire logic                 cmd_empty,
   input  wire cmd_type              cmd_word,
   output logic                      cmd_pop,
   input  wire logic                 rsp_full,
   output logic                      rsp_push,
   output rsp_type                   rsp_word
);

   localparam int HEAD_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int N_W     = $clog2(MAX_RESULTS);
   localparam int ENTRY_W = ID_W + BYTES_W;
   localparam int DELTA_W = BYTES_W + 2;
   localparam int SUM_W   = QUOTA_W + 2;
   localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'({1'b0, {(QUOTA_W - 1){1'b1}}});
   localparam logic signed [SUM_W-1:0] SUM_MIN = ~SUM_MAX;

   typedef enum logic {
      S_IDLE,
      S_TICK
   } state_type;

   state_type                  state_ff, state_in;
   logic signed [QUOTA_W-1:0]  used_ff, used_in;
   logic [ACTIVE_W-1:0]        active_ff, active_in;
   logic [HEAD_W-1:0]          head_ff, head_in;
   logic [FILL_W-1:0]          fill_ff, fill_in;
   logic                       ticked_ff, ticked_in;
   logic [N_W-1:0]             n_ff, n_in;

   logic [ENTRY_W-1:0]         wait_mem [QUEUE_DEPTH];
   logic [ENTRY_W-1:0]         rd_ff;
   logic                       mem_we;
   logic [HEAD_W-1:0]          tail;
   logic [HEAD_W:0]            tail_sum;
   logic [HEAD_W-1:0]          head_next;

   logic signed [QUOTA_W-1:0]  budget;
   logic                       can_go;
   logic signed [QUOTA_W:0]    drained;

   function automatic logic signed [QUOTA_W-1:0] charge(
      input logic signed [QUOTA_W-1:0] q,
      input logic signed [DELTA_W-1:0] delta
   );
      logic signed [SUM_W-1:0] sum;
      sum = {{2{q[QUOTA_W-1]}}, q} + {{(SUM_W - DELTA_W){delta[DELTA_W-1]}}, delta};
      if (sum > SUM_MAX) begin
         sum = SUM_MAX;
      end else if (sum < SUM_MIN) begin
         sum = SUM_MIN;
      end
      return sum[QUOTA_W-1:0];
   endfunction

   assign budget    = {{(QUOTA_W - MB_W - MB_SHIFT){1'b0}}, bandwidth_mb, {MB_SHIFT{1'b0}}};
   assign can_go    = (used_ff < budget) && (active_ff < max_active);
   assign tail_sum  = (HEAD_W + 1)'(head_ff) + (HEAD_W + 1)'(fill_ff);
   assign tail      = (tail_sum >= (HEAD_W + 1)'(QUEUE_DEPTH))
                      ? HEAD_W'(tail_sum - (HEAD_W + 1)'(QUEUE_DEPTH))
                      : HEAD_W'(tail_sum);
   assign head_next = (head_ff == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign drained   = {used_ff[QUOTA_W-1], used_ff} - (QUOTA_W + 1)'(cmd_word.drain);

   always_comb begin
      state_in  = state_ff;
      used_in   = used_ff;
      active_in = active_ff;
      head_in   = head_ff;
      fill_in   = fill_ff;
      ticked_in = ticked_ff;
      n_in      = n_ff;
      mem_we    = 1'b0;
      cmd_pop   = 1'b0;
      rsp_push  = 1'b0;
      rsp_word  = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (!cmd_empty && !rsp_full) begin
               cmd_pop       = 1'b1;
               rsp_word.ev   = EV_ACK;
               rsp_word.last = 1'b1;
               unique case (cmd_word.kind)
                  KIND_SUBMIT: begin
                     rsp_push         = 1'b1;
                     rsp_word.task_id = cmd_word.task_id;
                     priority if (fill_ff == '0 && can_go) begin
                        used_in     = charge(used_ff, DELTA_W'(cmd_word.est));
                        active_in   = active_ff + 1'b1;
                        rsp_word.ev = EV_DISPATCH;
                     end else if (fill_ff < FILL_W'(QUEUE_DEPTH)) begin
                        mem_we      = 1'b1;
                        fill_in     = fill_ff + 1'b1;
                        rsp_word.ev = EV_QUEUED;
                     end else begin
                        rsp_word.ev = EV_DROPPED;
                     end
                  end
                  KIND_COMPLETE: begin
                     rsp_push  = 1'b1;
                     active_in = (active_ff == '0) ? '0 : active_ff - 1'b1;
                     used_in   = charge(used_ff,
                                        DELTA_W'(cmd_word.used) - DELTA_W'(cmd_word.est));
                  end
                  KIND_TICK: begin
                     if (ticked_ff) begin
                        used_in = drained[QUOTA_W] ? '0 : drained[QUOTA_W-1:0];
                     end
                     ticked_in = 1'b1;
                     n_in      = '0;
                     state_in  = S_TICK;
                  end
                  KIND_CLEAR: begin
                     rsp_push = 1'b1;
                     fill_in  = '0;
                     head_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_TICK: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               if (n_ff != N_W'(MAX_RESULTS - 1) && fill_ff != '0 && can_go) begin
                  used_in          = charge(used_ff, DELTA_W'(rd_ff[BYTES_W-1:0]));
                  active_in        = active_ff + 1'b1;
                  head_in          = head_next;
                  fill_in          = fill_ff - 1'b1;
                  n_in             = n_ff + 1'b1;
                  rsp_word.ev      = EV_DISPATCH;
                  rsp_word.task_id = rd_ff[ENTRY_W-1:BYTES_W];
                  rsp_word.last    = 1'b0;
               end else begin
                  rsp_word.ev   = EV_ACK;
                  rsp_word.last = 1'b1;
                  state_in      = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_word.active     = active_in;
      rsp_word.used_quota = used_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         used_ff   <= '0;
         active_ff <= '0;
         head_ff   <= '0;
         fill_ff   <= '0;
         ticked_ff <= 1'b0;
         n_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         used_ff   <= used_in;
         active_ff <= active_in;
         head_ff   <= head_in;
         fill_ff   <= fill_in;
         ticked_ff <= ticked_in;
         n_ff      <= n_in;
      end
   end

   // read port follows the next head, so the oldest word is ready for a tick
   always_ff @(posedge clock) begin
      if (mem_we) begin
         wait_mem[tail] <= {cmd_word.task_id, cmd_word.est};
      end
      rd_ff <= wait_mem[head_in];
   end

endmodule

`default_nettype wire

/* rtl/bandwidth_quota_task_admitter.sv */
`timescale 1ns / 1ps
`default_nettype none

// Leaky-bucket task admitter.
// Input words enter on push/full: a word is taken when push is high and full low.
// Results leave on empty/pop: the oldest result sits on the rsp_ ports while
// empty is low and is taken when pop is high. rsp_last marks the final result
// of an input word. Write the registers through csr_we/csr_index/csr_wdata
// only while the block is idle; the block itself does not enforce this.
// Submit, completion and clear: one result each, registered in the front, the
// command queue and the result queue; the front takes no new word until it
// has handed the last one to the command queue.
// Tick: the front is busy on the drain (two multiplies, a reciprocal multiply
// by the constant in two halves and a sum); the back applies it, except on the
// first tick after reset, flooring the bucket at zero, then dispatches one
// queued task per cycle while the result queue has room, at most 63, and adds
// an acknowledge. The back reads the wait queue one entry per cycle.
// A short command queue parts front and back; a result queue parts the back
// from the receiver. When the receiver stops popping the back stalls, the
// command queue fills and full rises.
// Reset clears the bucket, active count and wait queue, and sets the budget
// to 100 MiB/s and the active limit to 10000. No clearing pass is needed.

module bandwidth_quota_task_admitter
   import adm_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   output logic                       full,
   input  wire logic [1:0]            req_kind,
   input  wire logic [ID_W-1:0]       req_task_id,
   input  wire logic [BYTES_W-1:0]    req_estimate_bytes,
   input  wire logic [BYTES_W-1:0]    req_used_bytes,
   input  wire logic [ELAPSED_W-1:0]  req_elapsed_us,
   output logic                       empty,
   input  wire logic                  pop,
   output logic [1:0]                 rsp_event_res,
   output logic [ID_W-1:0]            rsp_out_task_id,
   output logic [ACTIVE_W-1:0]        rsp_active_count,
   output logic signed [QUOTA_W-1:0]  rsp_used_quota_bytes,
   output logic                       rsp_last,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_W-1:0]      csr_wdata
);

   logic [MB_W-1:0]      mb_ff;
   logic [ACTIVE_W-1:0]  max_active_ff;

   cmd_type  front_word, back_word;
   logic     front_push, cmd_full, cmd_empty, cmd_pop;
   rsp_type  eng_word, rsp_out;
   logic     eng_push, rsp_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         mb_ff         <= BANDWIDTH_RESET;
         max_active_ff <= MAX_ACTIVE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BANDWIDTH:  mb_ff         <= csr_wdata[MB_W-1:0];
            CSR_MAX_ACTIVE: max_active_ff <= csr_wdata[ACTIVE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   adm_front u_front (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_kind           (req_kind),
      .req_task_id        (req_task_id),
      .req_estimate_bytes (req_estimate_bytes),
      .req_used_bytes     (req_used_bytes),
      .req_elapsed_us     (req_elapsed_us),
      .bandwidth_mb       (mb_ff),
      .cmd_push           (front_push),
      .cmd_full           (cmd_full),
      .cmd_word           (front_word)
   );

   adm_fifo #(
      .word_type (cmd_type),
      .DEPTH     (CMD_Q_DEPTH)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .push    (front_push),
      .full    (cmd_full),
      .wr_word (front_word),
      .pop     (cmd_pop),
      .empty   (cmd_empty),
      .rd_word (back_word)
   );

   adm_engine #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .bandwidth_mb (mb_ff),
      .max_active   (max_active_ff),
      .cmd_empty    (cmd_empty),
      .cmd_word     (back_word),
      .cmd_pop      (cmd_pop),
      .rsp_full     (rsp_full),
      .rsp_push     (eng_push),
      .rsp_word     (eng_word)
   );

   adm_fifo #(
      .word_type (rsp_type),
      .DEPTH     (RSP_Q_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (eng_push),
      .full    (rsp_full),
      .wr_word (eng_word),
      .pop     (pop),
      .empty   (empty),
      .rd_word (rsp_out)
   );

   assign rsp_event_res        = rsp_out.ev;
   assign rsp_out_task_id      = rsp_out.task_id;
   assign rsp_active_count     = rsp_out.active;
   assign rsp_used_quota_bytes = rsp_out.used_quota;
   assign rsp_last             = rsp_out.last;

endmodule

`default_nettype wire

/* rtl/adm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module adm_checker
   import adm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  full,
   input  wire logic                  empty,
   input  wire logic                  pop,
   input  wire logic [1:0]            rsp_event_res,
   input  wire logic [ID_W-1:0]       rsp_out_task_id,
   input  wire logic [ACTIVE_W-1:0]   rsp_active_count,
   input  wire logic signed [QUOTA_W-1:0] rsp_used_quota_bytes,
   input  wire logic                  rsp_last
);

   // after reset nothing is pending and the input side is open
   a_reset_idle: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("not idle after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_event_res) && $stable(rsp_out_task_id)
                            && $stable(rsp_active_count) && $stable(rsp_used_quota_bytes)
                            && $stable(rsp_last)))
      else $error("waiting result changed");

   a_ack_id: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_event_res == EV_ACK) |-> (rsp_out_task_id == '0 && rsp_last))
      else $error("acknowledge carries an id or is not last");

   a_dispatch_active: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_event_res == EV_DISPATCH) |-> (rsp_active_count != '0))
      else $error("dispatch with no active task");

   a_submit_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_event_res == EV_QUEUED || rsp_event_res == EV_DROPPED)) |-> rsp_last)
      else $error("queued or dropped word not last");

endmodule

bind bandwidth_quota_task_admitter adm_checker u_adm_checker (
   .clock                (clock),
   .reset                (reset),
   .full                 (full),
   .empty                (empty),
   .pop                  (pop),
   .rsp_event_res        (rsp_event_res),
   .rsp_out_task_id      (rsp_out_task_id),
   .rsp_active_count     (rsp_active_count),
   .rsp_used_quota_bytes (rsp_used_quota_bytes),
   .rsp_last             (rsp_last)
);

`default_nettype wire

/* tb/admission_check.sv */
`timescale 1ns / 1ps

module admission_check
   import adm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire logic                  full,
   input  wire logic [1:0]            req_kind,
   input  wire logic [ID_W-1:0]       req_task_id,
   input  wire logic [BYTES_W-1:0]    req_estimate_bytes,
   input  wire logic [BYTES_W-1:0]    req_used_bytes,
   input  wire logic [ELAPSED_W-1:0]  req_elapsed_us,
   input  wire logic                  empty,
   input  wire logic                  pop,
   input  wire logic [1:0]            rsp_event_res,
   input  wire logic [ID_W-1:0]       rsp_out_task_id,
   input  wire logic [ACTIVE_W-1:0]   rsp_active_count,
   input  wire logic signed [QUOTA_W-1:0] rsp_used_quota_bytes,
   input  wire logic                  rsp_last,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_W-1:0]      csr_wdata,
   output int                         fail_count,
   output int                         pending
);

   localparam int QD = QUEUE_DEPTH_DEFAULT;
   localparam longint QUOTA_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint QUOTA_MIN = -QUOTA_MAX - 1;

   typedef struct {
      event_type                  ev;
      logic [ID_W-1:0]            id;
      logic [ACTIVE_W-1:0]        active;
      logic signed [QUOTA_W-1:0]  quota;
      logic                       last;
   } outcome_type;

   outcome_type due_results[$];

   logic [ID_W-1:0]    wait_id [QD];
   logic [BYTES_W-1:0] wait_est [QD];
   int      head;
   int      fill;
   longint  quota;
   int      active;
   bit      ticked;
   int      bw_mb;
   int      active_limit;

   task automatic flag(string what);
      $display("%0t admission_check: %s", $time, what);
      fail_count++;
   endtask

   task automatic clear_model();
      head = 0;
      fill = 0;
      quota = 0;
      active = 0;
      ticked = 0;
      bw_mb = int'(BANDWIDTH_RESET);
      active_limit = int'(MAX_ACTIVE_RESET);
      due_results.delete();
   endtask

   function automatic bit slot_free();
      return quota < (longint'(bw_mb) <<< MB_SHIFT) && active < active_limit;
   endfunction

   task automatic charge(longint delta);
      longint s;
      s = quota + delta;
      if (s > QUOTA_MAX) s = QUOTA_MAX;
      if (s < QUOTA_MIN) s = QUOTA_MIN;
      quota = s;
   endtask

   task automatic note(event_type ev, logic [ID_W-1:0] id, logic last);
      outcome_type o;
      o = '{ev, id, active[ACTIVE_W-1:0], quota[QUOTA_W-1:0], last};
      due_results = {due_results, o};
   endtask

   task automatic admit_word(kind_type k, logic [ID_W-1:0] id, logic [BYTES_W-1:0] est,
                             logic [BYTES_W-1:0] used, logic [ELAPSED_W-1:0] us);
      int tail;
      int n;
      bit [63:0] drain;
      longint s;
      logic [ID_W-1:0] tid;
      case (k)
         KIND_SUBMIT: begin
            if (fill == 0 && slot_free()) begin
               charge(longint'(est));
               active++;
               note(EV_DISPATCH, id, 1'b1);
            end else if (fill < QD) begin
               tail = (head + fill) % QD;
               wait_id[tail] = id;
               wait_est[tail] = est;
               fill++;
               note(EV_QUEUED, id, 1'b1);
            end else begin
               note(EV_DROPPED, id, 1'b1);
            end
         end
         KIND_COMPLETE: begin
            if (active > 0) active--;
            charge(longint'(used) - longint'(est));
            note(EV_ACK, '0, 1'b1);
         end
         KIND_TICK: begin
            if (ticked) begin
               drain = ((64'(us) * 64'(bw_mb)) << MB_SHIFT) / 64'd1000000;
               s = quota - longint'(drain);
               quota = (s > 0) ? s : 0;
            end
            ticked = 1;
            n = 0;
            while (n < MAX_RESULTS - 1 && fill > 0 && slot_free()) begin
               tid = wait_id[head];
               charge(longint'(wait_est[head]));
               head = (head + 1) % QD;
               fill--;
               active++;
               note(EV_DISPATCH, tid, 1'b0);
               n++;
            end
            note(EV_ACK, '0, 1'b1);
         end
         default: begin
            fill = 0;
            head = 0;
            note(EV_ACK, '0, 1'b1);
         end
      endcase
   endtask

   always @(posedge clock) begin
      outcome_type exp;
      if (reset) begin
         clear_model();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BANDWIDTH:  bw_mb = int'(csr_wdata[MB_W-1:0]);
               CSR_MAX_ACTIVE: active_limit = int'(csr_wdata[ACTIVE_W-1:0]);
               default: ;
            endcase
         end
         if (push && !full)
            admit_word(kind_type'(req_kind), req_task_id, req_estimate_bytes,
                       req_used_bytes, req_elapsed_us);
         if (pop && !empty) begin
            if (due_results.size() == 0) begin
               flag($sformatf("unexpected word ev %0d id %h", rsp_event_res, rsp_out_task_id));
            end else begin
               exp = due_results[0];
               due_results.delete(0);
               if (rsp_event_res !== exp.ev || rsp_out_task_id !== exp.id ||
                   rsp_active_count !== exp.active || rsp_used_quota_bytes !== exp.quota ||
                   rsp_last !== exp.last)
                  flag($sformatf({"got ev %0d id %h act %0d quota %0d last %0b, ",
                                  "want ev %0d id %h act %0d quota %0d last %0b"},
                                 rsp_event_res, rsp_out_task_id, rsp_active_count,
                                 rsp_used_quota_bytes, rsp_last, exp.ev, exp.id,
                                 exp.active, exp.quota, exp.last));
            end
         end
      end
      pending <= due_results.size();
   end

endmodule

/* tb/bandwidth_quota_task_admitter_tb.sv */
`timescale 1ns / 1ps

module bandwidth_quota_task_admitter_tb;
   import adm_pkg::*;

   localparam int CYCLE_LIMIT   = 6000000;
   localparam int SETTLE_CYCLES = 40;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   logic [1:0]            req_kind = '0;
   logic [ID_W-1:0]       req_task_id = '0;
   logic [BYTES_W-1:0]    req_estimate_bytes = '0;
   logic [BYTES_W-1:0]    req_used_bytes = '0;
   logic [ELAPSED_W-1:0]  req_elapsed_us = '0;
   logic                  empty;
   logic                  pop = 1'b0;
   logic [1:0]            rsp_event_res;
   logic [ID_W-1:0]       rsp_out_task_id;
   logic [ACTIVE_W-1:0]   rsp_active_count;
   logic signed [QUOTA_W-1:0] rsp_used_quota_bytes;
   logic                  rsp_last;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_W-1:0]      csr_wdata = '0;
   int                    fail_count;
   int                    pending;

   int                    cycles = 0;
   int                    rsp_hold = 0;
   bit                    rsp_idling = 1'b0;
   bit                    req_idling = 1'b0;
   logic [BYTES_W-1:0]    est_cap;
   logic [BYTES_W-1:0]    open_est[$];

   always #2 clock = ~clock;

   bandwidth_quota_task_admitter dut (.*);
   admission_check quota_watch (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic int pause_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 92) return $urandom_range(3, 6);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (rsp_hold > 0) begin
         pop <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else begin
         pop <= 1'b1;
         if (rsp_idling && $urandom_range(0, 3) == 0) rsp_hold <= pause_len();
      end
   end

   task automatic send(kind_type k, logic [ID_W-1:0] id, logic [BYTES_W-1:0] est,
                       logic [BYTES_W-1:0] used, logic [ELAPSED_W-1:0] us);
      int gap;
      req_kind <= k;
      req_task_id <= id;
      req_estimate_bytes <= est;
      req_used_bytes <= used;
      req_elapsed_us <= us;
      push <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      gap = (req_idling && $urandom_range(0, 2) == 0) ? pause_len() : 0;
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold the sender until every outstanding word has come back
   task automatic quiesce();
      push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(logic [MB_W-1:0] bw, logic [ACTIVE_W-1:0] limit);
      quiesce();
      repeat (SETTLE_CYCLES) @(posedge clock);
      set_reg(CSR_BANDWIDTH, CSR_W'(bw));
      set_reg(CSR_MAX_ACTIVE, CSR_W'(limit));
      est_cap = (bw == 0) ? 32'd1 << MB_SHIFT : 32'((64'(bw) << MB_SHIFT) / 3);
   endtask

   task automatic random_word();
      int r;
      logic [BYTES_W-1:0] est;
      logic [BYTES_W-1:0] used;
      logic [BYTES_W-1:0] delta;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         est = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, est_cap);
         if (open_est.size() < 200) open_est = {open_est, est};
         send(KIND_SUBMIT, ID_W'($urandom), est, $urandom, ELAPSED_W'($urandom));
      end else if (r < 72) begin
         if (open_est.size() > 0 && $urandom_range(0, 7) != 0) begin
            est = open_est[0];
            open_est.delete(0);
            delta = $urandom_range(0, est_cap >> 3);
            if ($urandom_range(0, 1))
               used = (64'(est) + 64'(delta) > 64'hFFFF_FFFF) ? '1 : est + delta;
            else
               used = (est > delta) ? est - delta : '0;
         end else begin
            est = $urandom;
            used = $urandom;
         end
         send(KIND_COMPLETE, ID_W'($urandom), est, used, ELAPSED_W'($urandom));
      end else if (r < 94) begin
         send(KIND_TICK, ID_W'($urandom), $urandom, $urandom,
              ELAPSED_W'(($urandom_range(0, 9) == 0) ? $urandom
                                                     : $urandom_range(0, 250000)));
      end else begin
         send(KIND_CLEAR, ID_W'($urandom), $urandom, $urandom, ELAPSED_W'($urandom));
      end
   endtask

   task automatic run_phase(logic [MB_W-1:0] bw, logic [ACTIVE_W-1:0] limit, int words,
                            bit idle);
      configure(bw, limit);
      req_idling = idle;
      rsp_idling <= idle;
      open_est.delete();
      repeat (words) begin
         random_word();
         if ($urandom_range(0, 39) == 0) quiesce();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      req_idling = 1'b1;
      rsp_idling <= 1'b1;
      est_cap = 32'((64'(BANDWIDTH_RESET) << MB_SHIFT) / 3);

      // first tick skips the drain; then overshoot, drain down, dispatch queued
      send(KIND_TICK, 16'h0000, 32'h0, 32'h0, 24'hFFFFFF);
      send(KIND_SUBMIT, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 24'h0);
      send(KIND_SUBMIT, 16'h0000, 32'h0, 32'hFFFF_FFFF, 24'hFFFFFF);
      send(KIND_SUBMIT, 16'h1234, 32'h1, 32'h0, 24'h0);
      send(KIND_TICK, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'h0);
      send(KIND_TICK, 16'h0, 32'h0, 32'h0, 24'hFFFFFF);
      send(KIND_TICK, 16'h0, 32'h0, 32'h0, 24'hFFFFFF);
      send(KIND_TICK, 16'h0, 32'h0, 32'h0, 24'hFFFFFF);
      // completions, down to and past an empty active count
      send(KIND_COMPLETE, 16'h0, 32'hFFFF_FFFF, 32'h0, 24'h0);
      send(KIND_COMPLETE, 16'hFFFF, 32'h0, 32'hFFFF_FFFF, 24'hFFFFFF);
      send(KIND_COMPLETE, 16'h0, 32'h0, 32'h0, 24'h0);
      send(KIND_COMPLETE, 16'h0, 32'd5, 32'd3, 24'h0);
      send(KIND_SUBMIT, 16'hA5A5, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 24'h5A5A5A);
      send(KIND_SUBMIT, 16'h5A5A, 32'h0, 32'h0, 24'hA5A5A5);
      send(KIND_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFFFFFF);
      send(KIND_SUBMIT, 16'd7, 32'd100, 32'h0, 24'h0);
      // negative balance, floored by the next tick
      send(KIND_COMPLETE, 16'h0, 32'hFFFF_FFFF, 32'h0, 24'h0);
      send(KIND_TICK, 16'h0, 32'h0, 32'h0, 24'd1);
      send(KIND_TICK, 16'h0, 32'h0, 32'h0, 24'h800000);

      // fill the wait queue past its depth, then release it over the next two ticks
      configure(12'd4095, 16'd0);
      repeat (66) send(KIND_SUBMIT, ID_W'($urandom), $urandom_range(0, 1000), $urandom,
                       ELAPSED_W'($urandom));
      configure(12'd4095, 16'hFFFF);
      send(KIND_TICK, 16'h0, 32'h0, 32'h0, 24'hFFFFFF);
      send(KIND_TICK, 16'h0, 32'h0, 32'h0, 24'd10);

      run_phase(12'd1, 16'd4, 70, 1'b1);
      run_phase(12'd0, 16'hFFFF, 50, 1'b1);
      run_phase(12'd4095, 16'd2, 50, 1'b1);
      run_phase(MB_W'($urandom_range(2, 300)), ACTIVE_W'($urandom_range(1, 20)), 60, 1'b0);
      run_phase(BANDWIDTH_RESET, MAX_ACTIVE_RESET, 40, 1'b1);

      quiesce();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

/* sim.f */
rtl/adm_pkg.sv
rtl/adm_fifo.sv
rtl/adm_front.sv
rtl/adm_engine.sv
rtl/bandwidth_quota_task_admitter.sv
rtl/adm_checker.sv
tb/admission_check.sv
tb/bandwidth_quota_task_admitter_tb.sv
